[rtl/hfc_pkg.sv]
`default_nettype none
package hfc_pkg;

	typedef enum logic [1:0] {
		ACT_H2S   = 2'd0,
		ACT_S2H   = 2'd1,
		ACT_CHECK = 2'd2
	} action_t;

	localparam logic [15:0] HALF_INF     = 16'h7C00;
	localparam logic [15:0] HALF_QNAN    = 16'h7E00;
	localparam logic [31:0] SGL_INF      = 32'h7F800000;
	localparam logic [31:0] SGL_QNAN     = 32'h7FC00000;
	localparam logic [7:0]  SGL_EXP_MAX  = 8'hFF;
	localparam logic [4:0]  HALF_EXP_MAX = 5'h1F;
	localparam logic [7:0]  EXP_REBIAS   = 8'd112;
	localparam logic [7:0]  SUB_SHIFT_BASE = 8'd126;
	localparam logic [7:0]  OVF_EXP      = 8'd143;
	localparam logic [7:0]  MIN_SUB_EXP  = 8'd102;
	localparam logic [7:0]  SUB_NORM_EXP = 8'd103;

endpackage
`default_nettype wire

[rtl/half_single_float_converter.sv]
`default_nettype none
// Half/single precision bit-pattern converter.
// An item is taken at a rising edge with start high and busy low. busy is
// always low: the four-stage pipeline takes one item in every cycle.
// action selects the work: half to single (half_in), single to half
// (single_in, result in the low 16 bits of result_bits) or the exactness
// check of single_in, reported on is_exact. Unused fields read as zero.
// done is the valid bit of the fourth stage and stays high for exactly one
// cycle, with result_bits and is_exact valid in that cycle.
// Throughput is one item per cycle, fixed by the pipeline: register inputs,
// narrow with rounding, widen, then compare and select. The receiver cannot
// stall, so results are never held back.
// Items leave in the order they entered.
// arst_n clears all stages at once; items in flight are dropped and done
// stays low until new items have passed through.
module half_single_float_converter (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  action,
	input  wire logic [15:0] half_in,
	input  wire logic [31:0] single_in,
	output logic             done,
	output logic      [31:0] result_bits,
	output logic             is_exact
);
	import hfc_pkg::*;

	logic        valid_s1, valid_s2, valid_s3, valid_s4;
	logic [1:0]  action_s1, action_s2, action_s3;
	logic [15:0] half_s1, half_s2;
	logic [31:0] single_s1, single_s2, single_s3;
	logic [15:0] narrow_s2;
	logic [31:0] wide_s3;
	logic [31:0] result_s4;
	logic        exact_s4;

	logic [15:0] narrow_d;
	logic [15:0] widen_in;
	logic [31:0] wide_d;
	logic [31:0] result_d;
	logic        exact_d;

	hfc_narrow u_narrow (
		.single_val (single_s1),
		.half_val   (narrow_d)
	);

	// The check path widens the narrowed value; the plain path widens half_in.
	assign widen_in = (action_s2 == ACT_H2S) ? half_s2 : narrow_s2;

	hfc_widen u_widen (
		.half_val   (widen_in),
		.single_val (wide_d)
	);

	// For single to half, the narrowed half of an item in stage three sits in its single field.
	always_comb begin
		result_d = 32'd0;
		exact_d  = 1'b0;
		if (valid_s3) begin
			case (action_s3)
				ACT_H2S: result_d = wide_s3;
				ACT_S2H: result_d = {16'd0, single_s3[15:0]};
				ACT_CHECK: exact_d = (single_s3[30:23] != SGL_EXP_MAX) &&
					(wide_s3 == single_s3);
				default: result_d = 32'd0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
			valid_s4  <= 1'b0;
			action_s1 <= 2'd0;
			action_s2 <= 2'd0;
			action_s3 <= 2'd0;
			half_s1   <= 16'd0;
			half_s2   <= 16'd0;
			single_s1 <= 32'd0;
			single_s2 <= 32'd0;
			single_s3 <= 32'd0;
			narrow_s2 <= 16'd0;
			wide_s3   <= 32'd0;
			result_s4 <= 32'd0;
			exact_s4  <= 1'b0;
		end else begin
			valid_s1  <= start;
			action_s1 <= action;
			half_s1   <= half_in;
			single_s1 <= single_in;

			valid_s2  <= valid_s1;
			action_s2 <= action_s1;
			half_s2   <= half_s1;
			single_s2 <= single_s1;
			narrow_s2 <= narrow_d;

			valid_s3  <= valid_s2;
			action_s3 <= action_s2;
			wide_s3   <= wide_d;
			// For single to half, carry the rounded half in place of the
			// input, which that action no longer needs.
			single_s3 <= (action_s2 == ACT_S2H) ? {16'd0, narrow_s2} : single_s2;

			valid_s4  <= valid_s3;
			result_s4 <= result_d;
			exact_s4  <= exact_d;
		end
	end

	assign busy        = 1'b0;
	assign done        = valid_s4;
	assign result_bits = result_s4;
	assign is_exact    = exact_s4;

	a_exact_zero_bits: assert property (@(posedge clk) disable iff (!arst_n)
		is_exact |-> (result_bits == 32'd0))
		else $error("is_exact set with nonzero result bits");

	a_exact_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> (!is_exact && result_bits == 32'd0))
		else $error("result fields active without done");

	a_exact_from_check: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && action_s3 != ACT_CHECK) |=> !is_exact)
		else $error("is_exact set for an action other than the check");

	a_narrow_upper_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && action_s3 == ACT_S2H) |=> (done && result_bits[31:16] == 16'd0))
		else $error("single to half result has upper bits set");

endmodule
`default_nettype wire

[rtl/hfc_narrow.sv]
`default_nettype none
module hfc_narrow (
	input  wire logic [31:0] single_val,
	output logic      [15:0] half_val
);
	import hfc_pkg::*;

	logic        sgn;
	logic [7:0]  ex;
	logic [22:0] man;
	logic [23:0] full;
	logic [4:0]  shift;
	logic [4:0]  rnd_idx;
	logic [9:0]  sub_keep;
	logic        sub_rnd;
	logic        sub_sticky;
	logic [23:0] sub_mask;
	logic [10:0] sub_res;
	logic        nrm_inc;
	logic [14:0] nrm_res;
	logic [14:0] mag;

	always_comb begin
		sgn        = single_val[31];
		ex         = single_val[30:23];
		man        = single_val[22:0];
		full       = {1'b1, man};
		// Subnormal half: keep bits start at 2^-24, so the shift runs from 14 to 24.
		shift      = 5'(SUB_SHIFT_BASE - ex);
		rnd_idx    = shift - 5'd1;
		sub_keep   = 10'(full >> shift);
		sub_rnd    = full[rnd_idx];
		sub_mask   = (24'd1 << rnd_idx) - 24'd1;
		sub_sticky = |(full & sub_mask);
		// A carry out of the largest subnormal lands on the smallest normal.
		sub_res    = {1'b0, sub_keep} + 11'(sub_rnd & (sub_sticky | sub_keep[0]));
		nrm_inc    = man[12] & ((|man[11:0]) | man[13]);
		// A mantissa carry bumps the exponent; exponent 31 is then infinity.
		nrm_res    = {5'(ex - EXP_REBIAS), man[22:13]} + 15'(nrm_inc);

		if (ex == SGL_EXP_MAX) begin
			if (man == 23'd0) begin
				mag = HALF_INF[14:0];
			end else begin
				mag = HALF_QNAN[14:0] | {6'd0, man[21:13]};
			end
		end else if (ex == 8'd0) begin
			mag = 15'd0;
		end else if (ex >= OVF_EXP) begin
			mag = HALF_INF[14:0];
		end else if (ex <= EXP_REBIAS) begin
			if (ex < MIN_SUB_EXP) begin
				mag = 15'd0;
			end else begin
				mag = {4'd0, sub_res};
			end
		end else begin
			mag = nrm_res;
		end
		half_val = {sgn, mag};
	end

endmodule
`default_nettype wire

[rtl/hfc_widen.sv]
`default_nettype none
module hfc_widen (
	input  wire logic [15:0] half_val,
	output logic      [31:0] single_val
);
	import hfc_pkg::*;

	logic        sgn;
	logic [4:0]  ex;
	logic [9:0]  man;
	logic [3:0]  pos;
	logic [3:0]  nshift;
	logic [10:0] norm;
	logic [7:0]  sub_exp;

	always_comb begin
		sgn = half_val[15];
		ex  = half_val[14:10];
		man = half_val[9:0];
		pos = 4'd0;
		for (int i = 0; i < 10; i++) begin
			if (man[i]) begin
				pos = 4'(i);
			end
		end
		// Shift the leading one up to the hidden bit position.
		nshift  = 4'd10 - pos;
		norm    = 11'({1'b0, man} << nshift);
		sub_exp = SUB_NORM_EXP + {4'd0, pos};

		if (ex == 5'd0) begin
			if (man == 10'd0) begin
				single_val = {sgn, 31'd0};
			end else begin
				single_val = {sgn, sub_exp, norm[9:0], 13'd0};
			end
		end else if (ex == HALF_EXP_MAX) begin
			if (man == 10'd0) begin
				single_val = {sgn, SGL_INF[30:0]};
			end else begin
				single_val = {sgn, SGL_QNAN[30:0] | {8'd0, man, 13'd0}};
			end
		end else begin
			single_val = {sgn, {3'd0, ex} + EXP_REBIAS, man, 13'd0};
		end
	end

endmodule
`default_nettype wire
